// ===== rtl/accumulator_cpu_step_assert.svh =====
// accumulator_cpu_step_assert.svh: assertion macros for the accumulator core
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef ACCUMULATOR_CPU_STEP_ASSERT_SVH
`define ACCUMULATOR_CPU_STEP_ASSERT_SVH

// clocked check, masked while reset is applied
`define ACS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define ACS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/acs_pkg.sv =====
// acs_pkg: types and constants of the accumulator machine
// used by accumulator_cpu_step; no dependencies
`default_nettype none

package acs_pkg;

  // memory geometry
  localparam int unsigned MemDepth = 256;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  // opcode bytes
  localparam logic [7:0] OpHlt = 8'h00;
  localparam logic [7:0] OpLda = 8'h01;
  localparam logic [7:0] OpSta = 8'h02;
  localparam logic [7:0] OpAdd = 8'h03;
  localparam logic [7:0] OpSub = 8'h04;
  localparam logic [7:0] OpInp = 8'h05;
  localparam logic [7:0] OpOut = 8'h06;
  localparam logic [7:0] OpBrz = 8'h07;
  localparam logic [7:0] OpBrp = 8'h08;
  localparam logic [7:0] OpBra = 8'h09;

  // request operation codes
  localparam logic OperLoad = 1'b0;
  localparam logic OperExec = 1'b1;

  // request payload
  typedef struct packed {
    logic       operation;
    logic [7:0] load_address;
    logic [7:0] load_data;
    logic [7:0] input_value;
  } acs_req_t;

  // result payload
  typedef struct packed {
    logic [7:0] next_pc;
    logic [7:0] acc_value;
    logic       halted;
    logic       out_valid;
    logic [7:0] out_value;
    logic [7:0] opcode_done;
  } acs_rsp_t;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OPC  = 5'b00010,
    S_ARG  = 5'b00100,
    S_DAT  = 5'b01000,
    S_RESP = 5'b10000
  } acs_state_e;

endpackage

`default_nettype wire

// ===== rtl/accumulator_cpu_step.sv =====
// channel | valid      | stall       | payload
// request | in_valid_i | in_stall_o  | in_req_i  (acs_pkg::acs_req_t)
// result  | out_valid_o| out_stall_i | out_rsp_o (acs_pkg::acs_rsp_t)
//
// a load request goes from idle to response; an execute request also passes the
// opcode, operand and data states as needed, reading the single port memory.
// reset clears pc, accumulator, halt flag and the per-byte valid bits at once,
// so memory reads as zero without a clearing pass.
// a request is taken whenever the sequencer is idle, even while a finished
// result waits in the output register; the sequencer waits only if it must
// overwrite a result that is still stalled.
// accumulator_cpu_step: sequencer, state registers and memory
// depends on acs_pkg and accumulator_cpu_step_assert.svh
`default_nettype none

module accumulator_cpu_step (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire acs_pkg::acs_req_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output acs_pkg::acs_rsp_t     out_rsp_o
);

  import acs_pkg::*;

  localparam logic [8:0] AddrLim = 9'(MemDepth);

  acs_state_e state_q, state_d;

  logic [7:0] pc_q, pc_d;
  logic [7:0] acc_q, acc_d;
  logic       halt_q, halt_d;
  logic [7:0] opc_q, opc_d;
  logic       outv_q, outv_d;
  logic [7:0] outval_q, outval_d;
  logic [7:0] inp_q, inp_d;

  acs_rsp_t rsp_q, rsp_d;
  logic     res_valid_q, res_valid_d;

  // memory port
  logic [7:0]         mem_q [MemDepth];
  logic [MemDepth-1:0] mem_vld_q;
  logic               mem_re, mem_we;
  logic [7:0]         mem_addr, mem_wdata;
  logic               mem_in_range;
  logic [AddrW-1:0]   mem_idx;
  logic [7:0]         rdata_q;
  logic               rd_vld_q;
  logic [7:0]         rdata;

  logic in_fire, out_fire, take;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = res_valid_q && !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = res_valid_q;
  assign out_rsp_o   = rsp_q;

  assign mem_in_range = ({1'b0, mem_addr} < AddrLim);
  assign mem_idx      = mem_addr[AddrW-1:0];
  // bytes never written since reset read as zero
  assign rdata        = rd_vld_q ? rdata_q : 8'h00;

  // branch condition
  always_comb begin
    case (opc_q)
      OpBrz:   take = (acc_q == 8'h00);
      OpBrp:   take = !acc_q[7];
      OpBra:   take = 1'b1;
      default: take = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    acc_d       = acc_q;
    halt_d      = halt_q;
    opc_d       = opc_q;
    outv_d      = outv_q;
    outval_d    = outval_q;
    inp_d       = inp_q;
    rsp_d       = rsp_q;
    res_valid_d = res_valid_q && !out_fire;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = pc_q;
    mem_wdata   = acc_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          opc_d    = 8'h00;
          outv_d   = 1'b0;
          outval_d = 8'h00;
          inp_d    = in_req_i.input_value;
          if (in_req_i.operation == OperLoad) begin
            mem_we    = 1'b1;
            mem_addr  = in_req_i.load_address;
            mem_wdata = in_req_i.load_data;
            state_d   = S_RESP;
          end else if (halt_q) begin
            state_d = S_RESP;
          end else begin
            // opcode fetch
            mem_re  = 1'b1;
            pc_d    = pc_q + 8'd1;
            state_d = S_OPC;
          end
        end
      end

      S_OPC: begin
        opc_d   = rdata;
        state_d = S_RESP;
        case (rdata)
          OpHlt: halt_d = 1'b1;
          OpInp: acc_d = inp_q;
          OpOut: begin
            outv_d   = 1'b1;
            outval_d = acc_q;
          end
          default: begin
            if (rdata inside {OpLda, OpSta, OpAdd, OpSub, OpBrz, OpBrp, OpBra}) begin
              // operand fetch
              mem_re  = 1'b1;
              pc_d    = pc_q + 8'd1;
              state_d = S_ARG;
            end
          end
        endcase
      end

      S_ARG: begin
        state_d  = S_RESP;
        mem_addr = rdata;
        case (opc_q)
          OpSta: mem_we = 1'b1;
          OpLda, OpAdd, OpSub: begin
            mem_re  = 1'b1;
            state_d = S_DAT;
          end
          default: begin
            if (take) begin
              pc_d = rdata;
            end
          end
        endcase
      end

      S_DAT: begin
        state_d = S_RESP;
        case (opc_q)
          OpAdd:   acc_d = acc_q + rdata;
          OpSub:   acc_d = acc_q - rdata;
          default: acc_d = rdata;
        endcase
      end

      S_RESP: begin
        // push once the output register is free or being drained
        if (!res_valid_q || !out_stall_i) begin
          rsp_d.next_pc     = pc_q;
          rsp_d.acc_value   = acc_q;
          rsp_d.halted      = halt_q;
          rsp_d.out_valid   = outv_q;
          rsp_d.out_value   = outval_q;
          rsp_d.opcode_done = opc_q;
          res_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= 8'h00;
      acc_q       <= 8'h00;
      halt_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      acc_q       <= acc_d;
      halt_q      <= halt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    opc_q    <= opc_d;
    outv_q   <= outv_d;
    outval_q <= outval_d;
    inp_q    <= inp_d;
    rsp_q    <= rsp_d;
  end

  // byte valid bits and read valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we && mem_in_range) begin
        mem_vld_q[mem_idx] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= mem_in_range && mem_vld_q[mem_idx];
      end
    end
  end

  // memory array, one port
  always_ff @(posedge clk_i) begin
    if (mem_we && mem_in_range) begin
      mem_q[mem_idx] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_idx];
    end
  end

  // checks
`include "accumulator_cpu_step_assert.svh"

  `ACS_ASSERT(a_port_single, !(mem_re && mem_we), "memory read and write in one cycle")
  `ACS_ASSERT(a_halt_sticky, halt_q |=> halt_q, "halt flag cleared without reset")
  `ACS_ASSERT(a_push_from_resp, $rose(res_valid_q) |-> $past(state_q == S_RESP), "result pushed outside response state")
  `ACS_ASSERT_ALWAYS(a_out_needs_opc, (res_valid_q && rsp_q.out_valid) |-> (rsp_q.opcode_done == OpOut), "output flag without OUT opcode")

endmodule

`default_nettype wire

// ===== tb/tb_accumulator_cpu_step.sv =====
`timescale 1ns / 1ps
// tb_accumulator_cpu_step: self-checking testbench for the accumulator machine
// drives load and execute requests, predicts every result and checks each field
// depends on acs_pkg and accumulator_cpu_step

module tb_accumulator_cpu_step;
  import acs_pkg::*;

  localparam int NumRows        = 35;
  localparam int TailStart      = 30;   // rows from here on halt the machine
  localparam int RandomRequests = 450;
  localparam int PauseAt        = 200;  // random request at which the sender drains
  localparam int LongHoldAt     = 150;  // result count at which the receiver holds off
  localparam int LongHoldCycles = 60;
  localparam int MaxGap         = 10;
  localparam int SettleCycles   = 20;

  localparam acs_rsp_t NoRsp = '0;

  typedef struct packed {
    acs_req_t req;
    logic     at_pc;  // load address replaced by the current pc
    logic     typed;  // rsp holds the expected result
    acs_rsp_t rsp;
  } stim_row_t;

  // directed program: input, add with wrap, branches taken and untaken, pc wrap,
  // output, load, store, undefined opcode; the tail halts the machine for good
  localparam stim_row_t StimRows [NumRows] = '{
    '{'{OperLoad, 8'h00, OpInp, 8'hFF}, 1'b0, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{'{OperLoad, 8'h01, OpAdd, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h02, 8'hFF, 8'h5A}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'hFF, 8'h01, 8'hA5}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h03, OpBrz, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h04, 8'hFE, 8'hFF}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'hFE, OpSub, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h05, OpBrp, 8'h33}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h07, OpOut, 8'hCC}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h08, OpLda, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h0A, OpSta, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h0B, 8'h80, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h0C, 8'hFF, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h0D, OpBrp, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h0E, 8'h10, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h10, OpBra, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'hFF}, 1'b0, 1'b1, '{8'h01, 8'hFF, 1'b0, 1'b0, 8'h00, OpInp}},
    '{'{OperExec, 8'hFF, 8'hFF, 8'h00}, 1'b0, 1'b1, '{8'h03, 8'h00, 1'b0, 1'b0, 8'h00, OpAdd}},
    '{'{OperExec, 8'hC3, 8'h3C, 8'h11}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h3C, 8'hC3, 8'h22}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'h80}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h55, 8'hAA, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'hAA, 8'h55, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'h00, OpHlt, 8'h3C}, 1'b1, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'h5A}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NoRsp},
    '{'{OperLoad, 8'hFF, 8'hAA, 8'h00}, 1'b0, 1'b0, NoRsp},
    '{'{OperExec, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NoRsp}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_stall;
  acs_req_t req_payload = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  acs_rsp_t rsp_payload;

  // machine state as the predictor sees it
  logic [7:0] mach_mem [MemDepth] = '{default: 8'h00};
  logic [7:0] mach_pc = 8'h00;
  logic [7:0] mach_acc = 8'h00;
  logic       mach_halted = 1'b0;

  acs_rsp_t    pending_results [$];
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  logic        send_quiet = 1'b0;
  logic        recv_quiet = 1'b0;

  accumulator_cpu_step dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_req_i   (req_payload),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_rsp_o  (rsp_payload)
  );

  // clock and reset
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // run limit, far above the slowest legal run (about 100 us)
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [7:0] mem_byte(input logic [7:0] addr);
    return (addr < MemDepth) ? mach_mem[addr] : 8'h00;
  endfunction

  // byte at the pc, pc stepped on with wrap
  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b = mem_byte(mach_pc);
    mach_pc = mach_pc + 8'd1;
    return b;
  endfunction

  // applies one request to the machine state and returns its result
  function automatic acs_rsp_t step_machine(input acs_req_t r);
    acs_rsp_t   res;
    logic [7:0] opc;
    logic [7:0] arg;
    logic       take;
    res = '0;
    if (r.operation == OperLoad) begin
      if (r.load_address < MemDepth) mach_mem[r.load_address] = r.load_data;
    end else if (!mach_halted) begin
      opc = fetch_byte();
      res.opcode_done = opc;
      case (opc)
        OpHlt: mach_halted = 1'b1;
        OpLda: mach_acc = mem_byte(fetch_byte());
        OpSta: begin
          arg = fetch_byte();
          if (arg < MemDepth) mach_mem[arg] = mach_acc;
        end
        OpAdd: mach_acc = mach_acc + mem_byte(fetch_byte());
        OpSub: mach_acc = mach_acc - mem_byte(fetch_byte());
        OpInp: mach_acc = r.input_value;
        OpOut: begin
          res.out_valid = 1'b1;
          res.out_value = mach_acc;
        end
        OpBrz, OpBrp, OpBra: begin
          take = (opc == OpBra) || (opc == OpBrz && mach_acc == 8'h00) ||
                 (opc == OpBrp && !mach_acc[7]);
          arg = fetch_byte();
          if (take) mach_pc = arg;
        end
        default: ;
      endcase
    end
    res.next_pc   = mach_pc;
    res.acc_value = mach_acc;
    res.halted    = mach_halted;
    return res;
  endfunction

  // defined opcode most of the time, never a halt
  function automatic logic [7:0] pick_opcode();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(8'h0A, 8'hFF));
    return 8'($urandom_range(OpLda, OpBra));
  endfunction

  // offers one request after a random gap and records its expected result
  task automatic push_request(input acs_req_t r, input logic typed, input acs_rsp_t want);
    int       gap;
    acs_rsp_t predicted;
    if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_payload <= r;
    do @(posedge clk); while (req_stall);
    predicted = step_machine(r);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic send_load(input logic [7:0] addr, input logic [7:0] data);
    acs_req_t r;
    r.operation    = OperLoad;
    r.load_address = addr;
    r.load_data    = data;
    r.input_value  = 8'($urandom);
    push_request(r, 1'b0, NoRsp);
  endtask

  // a halt is patched over so that the machine keeps running
  task automatic send_exec();
    acs_req_t r;
    if (mem_byte(mach_pc) == OpHlt) send_load(mach_pc, pick_opcode());
    r.operation    = OperExec;
    r.load_address = 8'($urandom);
    r.load_data    = 8'($urandom);
    r.input_value  = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
    push_request(r, 1'b0, NoRsp);
  endtask

  task automatic run_rows(input int first, input int last);
    acs_req_t r;
    for (int i = first; i < last; i++) begin
      r = StimRows[i].req;
      if (StimRows[i].at_pc) r.load_address = mach_pc;
      push_request(r, StimRows[i].typed, StimRows[i].rsp);
    end
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // request side: directed rows, random programs, then the halt rows
  initial begin : sender
    logic [7:0] opc;
    logic [7:0] arg;
    logic       paused;
    paused = 1'b0;
    wait (rst_n);
    @(posedge clk);
    run_rows(0, TailStart);
    wait_drained();
    while (requests_sent < TailStart + RandomRequests) begin
      if (!paused && requests_sent >= TailStart + PauseAt) begin
        paused = 1'b1;
        wait_drained();
      end
      case ($urandom_range(0, 9))
        0, 1: send_load(8'($urandom), 8'($urandom));
        2: send_exec();
        default: begin
          // instruction written at the pc with a random operand and sometimes data, then run
          opc = pick_opcode();
          send_load(mach_pc, opc);
          if (opc <= OpBra && opc != OpInp && opc != OpOut) begin
            case ($urandom_range(0, 3))
              0: arg = 8'h00;
              1: arg = 8'hFF;
              default: arg = 8'($urandom);
            endcase
            send_load(mach_pc + 8'd1, arg);
            if (opc inside {OpLda, OpAdd, OpSub} && $urandom_range(0, 1) == 1)
              send_load(arg, 8'($urandom));
          end
          repeat ($urandom_range(1, 3)) send_exec();
        end
      endcase
    end
    run_rows(TailStart, NumRows);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, field by field checks
  initial begin : receiver
    acs_rsp_t got;
    acs_rsp_t want;
    int       hold;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
      if (results_seen == LongHoldAt) hold = LongHoldCycles;
      else hold = recv_quiet ? 0 : $urandom_range(0, MaxGap);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!rsp_valid);
      got = rsp_payload;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result arrived with no request pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.next_pc !== want.next_pc) begin
          $error("next_pc: expected %0h, got %0h", want.next_pc, got.next_pc);
          error_count++;
        end
        if (got.acc_value !== want.acc_value) begin
          $error("acc_value: expected %0h, got %0h", want.acc_value, got.acc_value);
          error_count++;
        end
        if (got.halted !== want.halted) begin
          $error("halted: expected %0h, got %0h", want.halted, got.halted);
          error_count++;
        end
        if (got.out_valid !== want.out_valid) begin
          $error("out_valid: expected %0h, got %0h", want.out_valid, got.out_valid);
          error_count++;
        end
        if (got.out_value !== want.out_value) begin
          $error("out_value: expected %0h, got %0h", want.out_value, got.out_value);
          error_count++;
        end
        if (got.opcode_done !== want.opcode_done) begin
          $error("opcode_done: expected %0h, got %0h", want.opcode_done, got.opcode_done);
          error_count++;
        end
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/acs_pkg.sv
rtl/accumulator_cpu_step.sv
tb/tb_accumulator_cpu_step.sv
